// ----- rtl/wfu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfu_pkg
// Shared types and constants for the WebSocket frame unmasker.
// ----------------------------------------------------------------------------
package wfu_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned KindW  = 2;
    localparam int unsigned CodeW  = 2;
    localparam int unsigned LenW   = 16;
    localparam int unsigned MaskW  = 32;

    // Result kinds
    localparam logic [KindW-1:0] KIND_DATA  = 2'd0;
    localparam logic [KindW-1:0] KIND_EMPTY = 2'd1;
    localparam logic [KindW-1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [CodeW-1:0] ERR_NOT_FINAL = 2'd0;
    localparam logic [CodeW-1:0] ERR_RSV_SET   = 2'd1;
    localparam logic [CodeW-1:0] ERR_NO_MASK   = 2'd2;
    localparam logic [CodeW-1:0] ERR_LEN64     = 2'd3;

    // Header bit fields and length codes
    localparam logic [ByteW-1:0] FIN_BIT   = 8'b1000_0000;
    localparam logic [ByteW-1:0] RSV_BITS  = 8'b0111_0000;
    localparam logic [ByteW-1:0] MASK_BIT  = 8'b1000_0000;
    localparam logic [ByteW-1:0] LEN_BITS  = 8'b0111_1111;
    localparam logic [6:0]       LEN_EXT16 = 7'd126;
    localparam logic [6:0]       LEN_EXT64 = 7'd127;

    typedef enum logic [4:0] {
        PH_HDR0    = 5'b00001,
        PH_HDR1    = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_MASK    = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    typedef struct packed {
        logic             valid;
        logic [KindW-1:0] kind;
        logic [ByteW-1:0] data;
        logic             last;
        logic [CodeW-1:0] code;
    } t_result;

endpackage

// ----- rtl/websocket_frame_unmasker.sv -----
`timescale 1ns / 1ps
// An accepted byte is held in the input register, and its result then in the result register.
// Throughput: one byte per cycle; a payload byte, the last mask byte of an empty frame and a
// faulty header byte yield one result each, other header bytes none.
// The parse step sets the rate; a held result register stalls a byte that makes a result.
// Reset (synchronous, active low) clears both pipeline stages and the parser
// state; after a protocol error the block drops all bytes until reset.
// ----------------------------------------------------------------------------
// websocket_frame_unmasker
// Parses client-to-server WebSocket frame headers and unmasks payload bytes.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // byte input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [wfu_pkg::ByteW-1:0]   i_in_byte,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [wfu_pkg::KindW-1:0]   o_out_kind,
    output logic [wfu_pkg::ByteW-1:0]   o_out_byte,
    output logic                        o_last_of_frame,
    output logic [wfu_pkg::CodeW-1:0]   o_error_code
);

    // Input register: hold one accepted byte for the parse step.
    logic                      r_in_valid;
    logic [wfu_pkg::ByteW-1:0] r_in_byte;

    wfu_pkg::t_result parse_res;
    wfu_pkg::t_result out_res;
    logic             out_free;
    logic             advance;
    logic             in_accept;

    // Advance the held byte when it makes no result, or when the result
    // register can take the request it makes.
    assign advance    = r_in_valid && (!parse_res.valid || out_free);
    // Accept a new byte whenever the input register is empty or moving on.
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_in_byte;
        end
    end

    // Parser state only moves when the held byte advances.
    wfu_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .o_result  (parse_res)
    );

    wfu_pkg::t_result load_res;

    // Present a request to the result register only for a live byte.
    always_comb begin
        load_res       = parse_res;
        load_res.valid = parse_res.valid && r_in_valid;
    end

    wfu_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (load_res),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_result (out_res)
    );

    assign o_out_valid     = out_res.valid;
    assign o_out_kind      = out_res.kind;
    assign o_out_byte      = out_res.data;
    assign o_last_of_frame = out_res.last;
    assign o_error_code    = out_res.code;

endmodule

// ----- rtl/wfu_parse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfu_parse
// Frame header parser and payload unmasker: one byte per advance.
// ----------------------------------------------------------------------------
module wfu_parse (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic [wfu_pkg::ByteW-1:0]   i_byte,
    output wfu_pkg::t_result            o_result
);

    wfu_pkg::t_phase           r_phase, n_phase;
    logic [1:0]                r_hcnt, n_hcnt;
    logic [wfu_pkg::MaskW-1:0] r_mask, n_mask;
    logic [wfu_pkg::LenW-1:0]  r_rem, n_rem;
    logic [1:0]                r_pos, n_pos;
    logic                      r_halted, n_halted;

    logic [wfu_pkg::ByteW-1:0] key;
    logic [wfu_pkg::LenW-1:0]  rem_dec;
    logic [6:0]                len_code;

    always_comb begin
        case (r_pos)
            2'd0:    key = r_mask[31:24];
            2'd1:    key = r_mask[23:16];
            2'd2:    key = r_mask[15:8];
            default: key = r_mask[7:0];
        endcase
    end

    assign rem_dec  = r_rem - wfu_pkg::LenW'(1);
    assign len_code = i_byte[6:0] & wfu_pkg::LEN_BITS[6:0];

    always_comb begin
        n_phase  = r_phase;
        n_hcnt   = r_hcnt;
        n_mask   = r_mask;
        n_rem    = r_rem;
        n_pos    = r_pos;
        n_halted = r_halted;
        o_result = '0;

        if (!r_halted) begin
            unique case (r_phase)
                wfu_pkg::PH_HDR0: begin
                    if ((i_byte & wfu_pkg::FIN_BIT) == '0) begin
                        o_result.valid = 1'b1;
                        o_result.kind  = wfu_pkg::KIND_ERROR;
                        o_result.code  = wfu_pkg::ERR_NOT_FINAL;
                        n_halted       = 1'b1;
                    end else if ((i_byte & wfu_pkg::RSV_BITS) != '0) begin
                        o_result.valid = 1'b1;
                        o_result.kind  = wfu_pkg::KIND_ERROR;
                        o_result.code  = wfu_pkg::ERR_RSV_SET;
                        n_halted       = 1'b1;
                    end else begin
                        n_phase = wfu_pkg::PH_HDR1;
                    end
                end
                wfu_pkg::PH_HDR1: begin
                    if ((i_byte & wfu_pkg::MASK_BIT) == '0) begin
                        o_result.valid = 1'b1;
                        o_result.kind  = wfu_pkg::KIND_ERROR;
                        o_result.code  = wfu_pkg::ERR_NO_MASK;
                        n_halted       = 1'b1;
                    end else if (len_code == wfu_pkg::LEN_EXT64) begin
                        o_result.valid = 1'b1;
                        o_result.kind  = wfu_pkg::KIND_ERROR;
                        o_result.code  = wfu_pkg::ERR_LEN64;
                        n_halted       = 1'b1;
                    end else begin
                        n_hcnt = 2'd0;
                        n_mask = '0;
                        if (len_code == wfu_pkg::LEN_EXT16) begin
                            n_rem   = '0;
                            n_phase = wfu_pkg::PH_EXTLEN;
                        end else begin
                            n_rem   = wfu_pkg::LenW'(len_code);
                            n_phase = wfu_pkg::PH_MASK;
                        end
                    end
                end
                wfu_pkg::PH_EXTLEN: begin
                    n_rem = {r_rem[wfu_pkg::LenW-9:0], i_byte};
                    if (r_hcnt == 2'd0) begin
                        n_hcnt = 2'd1;
                    end else begin
                        n_hcnt  = 2'd0;
                        n_phase = wfu_pkg::PH_MASK;
                    end
                end
                wfu_pkg::PH_MASK: begin
                    n_mask = {r_mask[wfu_pkg::MaskW-9:0], i_byte};
                    if (r_hcnt != 2'd3) begin
                        n_hcnt = r_hcnt + 2'd1;
                    end else begin
                        n_hcnt = 2'd0;
                        n_pos  = 2'd0;
                        if (r_rem == '0) begin
                            // zero-length frame: report once the mask is consumed
                            n_phase        = wfu_pkg::PH_HDR0;
                            o_result.valid = 1'b1;
                            o_result.kind  = wfu_pkg::KIND_EMPTY;
                        end else begin
                            n_phase = wfu_pkg::PH_PAYLOAD;
                        end
                    end
                end
                wfu_pkg::PH_PAYLOAD: begin
                    n_pos          = r_pos + 2'd1;
                    n_rem          = rem_dec;
                    o_result.valid = 1'b1;
                    o_result.kind  = wfu_pkg::KIND_DATA;
                    o_result.data  = i_byte ^ key;
                    o_result.last  = (rem_dec == '0);
                    if (rem_dec == '0) begin
                        n_phase = wfu_pkg::PH_HDR0;
                    end
                end
                default: begin
                    n_phase = wfu_pkg::PH_HDR0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wfu_pkg::PH_HDR0;
            r_hcnt   <= '0;
            r_mask   <= '0;
            r_rem    <= '0;
            r_pos    <= '0;
            r_halted <= 1'b0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_hcnt   <= n_hcnt;
            r_mask   <= n_mask;
            r_rem    <= n_rem;
            r_pos    <= n_pos;
            r_halted <= n_halted;
        end
    end

endmodule

// ----- rtl/wfu_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfu_out_reg
// Result register holding one request until the receiver takes it.
// ----------------------------------------------------------------------------
module wfu_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wfu_pkg::t_result i_result,
    input  logic             i_stall,
    output logic             o_free,
    output wfu_pkg::t_result o_result
);

    logic                                r_valid;
    logic [wfu_pkg::KindW-1:0]           r_kind;
    logic [wfu_pkg::ByteW-1:0]           r_data;
    logic                                r_last;
    logic [wfu_pkg::CodeW-1:0]           r_code;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_result.valid) begin
            r_kind <= i_result.kind;
            r_data <= i_result.data;
            r_last <= i_result.last;
            r_code <= i_result.code;
        end
    end

    always_comb begin
        o_result.valid = r_valid;
        o_result.kind  = r_kind;
        o_result.data  = r_data;
        o_result.last  = r_last;
        o_result.code  = r_code;
    end

endmodule

// ----- verif/websocket_frame_unmasker_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_unmasker_test
// Self-checking bench for the frame unmasker. Well-formed masked frames with
// random lengths, opcodes, keys and payloads are fed byte by byte. One bad
// header closes the run, since a protocol error halts the block until reset.
// A byte-level predictor of the parser produces the expected results, and
// a monitor compares every accepted result with them in order.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker_test;

    // One expected result of the parser
    typedef struct packed {
        logic [wfu_pkg::KindW-1:0] kind;
        logic [wfu_pkg::ByteW-1:0] data;
        logic                      last;
        logic [wfu_pkg::CodeW-1:0] code;
    } t_frame_result;

    localparam int IDLE_LIMIT  = 5000; // cycles with no handshake on either side
    localparam int TAIL_CYCLES = 16;   // drain time after the last result
    localparam int HOLD_CYCLES = 400;  // long receiver hold-off
    localparam int HOLD_AFTER  = 150;  // results seen before the hold-off starts
    localparam int ITEM_TARGET = 750;

    logic                       i_clk;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic [wfu_pkg::ByteW-1:0]  i_in_byte   = '0;
    logic                       i_out_stall = 1'b0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic [wfu_pkg::KindW-1:0]  o_out_kind;
    logic [wfu_pkg::ByteW-1:0]  o_out_byte;
    logic                       o_last_of_frame;
    logic [wfu_pkg::CodeW-1:0]  o_error_code;

    // Stimulus and scoreboard storage
    logic [wfu_pkg::ByteW-1:0]  stream_bytes[$];
    t_frame_result              expected_results[$];

    // Predictor copy of the parser state
    wfu_pkg::t_phase            phase      = wfu_pkg::PH_HDR0;
    logic [1:0]                 hdr_count  = '0;
    logic [wfu_pkg::MaskW-1:0]  mask_key   = '0;
    logic [wfu_pkg::LenW-1:0]   bytes_left = '0;
    logic [1:0]                 key_pos    = '0;
    logic                       halted     = 1'b0;

    // Bench bookkeeping
    bit                byte_busy    = 1'b0; // a request is on the bus
    int                send_gap     = 0;
    int                stall_left   = 0;
    int                hold_left    = 0;
    bit                hold_done    = 1'b0;
    bit                calm         = 1'b0; // no idling on either side
    int                cycle_count  = 0;
    int                idle_cycles  = 0;
    int                results_seen = 0;
    int                fail_count   = 0;

    websocket_frame_unmasker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_kind      (o_out_kind),
        .o_out_byte      (o_out_byte),
        .o_last_of_frame (o_last_of_frame),
        .o_error_code    (o_error_code)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 65) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_count < 40) begin
            $display("MISMATCH @%0t: %s", $time, what);
        end
        fail_count++;
    endtask

    task automatic post_result(input logic [wfu_pkg::KindW-1:0] kind,
                               input logic [wfu_pkg::ByteW-1:0] data,
                               input logic last,
                               input logic [wfu_pkg::CodeW-1:0] code);
        t_frame_result r;
        r.kind = kind;
        r.data = data;
        r.last = last;
        r.code = code;
        expected_results.push_back(r);
    endtask

    // Flag a header fault and freeze the parser until reset.
    task automatic raise_error(input logic [wfu_pkg::CodeW-1:0] code);
        halted = 1'b1;
        post_result(wfu_pkg::KIND_ERROR, '0, 1'b0, code);
    endtask

    // Advance the parser by one accepted byte and record what it yields.
    task automatic unmask_byte(input logic [wfu_pkg::ByteW-1:0] b);
        logic [wfu_pkg::ByteW-1:0] key;
        if (halted) return;
        case (phase)
            wfu_pkg::PH_HDR0: begin
                // FIN is checked ahead of the reserved bits
                if ((b & wfu_pkg::FIN_BIT) == '0) raise_error(wfu_pkg::ERR_NOT_FINAL);
                else if ((b & wfu_pkg::RSV_BITS) != '0) raise_error(wfu_pkg::ERR_RSV_SET);
                else phase = wfu_pkg::PH_HDR1;
            end
            wfu_pkg::PH_HDR1: begin
                // the mask bit is checked ahead of the length code
                if ((b & wfu_pkg::MASK_BIT) == '0) raise_error(wfu_pkg::ERR_NO_MASK);
                else if (b[6:0] == wfu_pkg::LEN_EXT64) raise_error(wfu_pkg::ERR_LEN64);
                else begin
                    hdr_count = '0;
                    mask_key  = '0;
                    if (b[6:0] == wfu_pkg::LEN_EXT16) begin
                        bytes_left = '0;
                        phase      = wfu_pkg::PH_EXTLEN;
                    end else begin
                        bytes_left = {9'd0, b[6:0]};
                        phase      = wfu_pkg::PH_MASK;
                    end
                end
            end
            wfu_pkg::PH_EXTLEN: begin
                bytes_left = {bytes_left[7:0], b};
                if (hdr_count == 2'd0) begin
                    hdr_count = 2'd1;
                end else begin
                    hdr_count = '0;
                    phase     = wfu_pkg::PH_MASK;
                end
            end
            wfu_pkg::PH_MASK: begin
                mask_key = {mask_key[23:0], b};
                if (hdr_count != 2'd3) begin
                    hdr_count = hdr_count + 2'd1;
                end else begin
                    hdr_count = '0;
                    key_pos   = '0;
                    // a zero length still eats the whole key, then reports empty
                    if (bytes_left == '0) begin
                        phase = wfu_pkg::PH_HDR0;
                        post_result(wfu_pkg::KIND_EMPTY, '0, 1'b0, wfu_pkg::ERR_NOT_FINAL);
                    end else begin
                        phase = wfu_pkg::PH_PAYLOAD;
                    end
                end
            end
            wfu_pkg::PH_PAYLOAD: begin
                key        = mask_key[8*(3 - int'(key_pos)) +: 8];
                key_pos    = key_pos + 2'd1;
                bytes_left = bytes_left - 16'd1;
                post_result(wfu_pkg::KIND_DATA, b ^ key, bytes_left == '0,
                            wfu_pkg::ERR_NOT_FINAL);
                if (bytes_left == '0) phase = wfu_pkg::PH_HDR0;
            end
            default: phase = wfu_pkg::PH_HDR0;
        endcase
    endtask

    // Append one well-formed masked frame with a random payload.
    task automatic queue_frame(input logic [3:0] opcode, input int len,
                               input bit ext16, input logic [wfu_pkg::MaskW-1:0] key);
        logic [wfu_pkg::LenW-1:0] len16;
        len16 = wfu_pkg::LenW'(len);
        stream_bytes.push_back(wfu_pkg::FIN_BIT | {4'd0, opcode});
        if (ext16) begin
            stream_bytes.push_back({1'b1, wfu_pkg::LEN_EXT16});
            stream_bytes.push_back(len16[15:8]);
            stream_bytes.push_back(len16[7:0]);
        end else begin
            stream_bytes.push_back({1'b1, len16[6:0]});
        end
        for (int i = 3; i >= 0; i--) stream_bytes.push_back(key[8*i +: 8]);
        repeat (len) stream_bytes.push_back(wfu_pkg::ByteW'($urandom));
    endtask

    task automatic queue_random_frame();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)      queue_frame(4'($urandom), $urandom_range(0, 8), 1'b0, $urandom);
        else if (pick < 80) queue_frame(4'($urandom), $urandom_range(9, 40), 1'b0, $urandom);
        else if (pick < 92) queue_frame(4'($urandom), $urandom_range(0, 150), 1'b1, $urandom);
        else if (pick < 97) queue_frame(4'($urandom), $urandom_range(120, 125), 1'b0, $urandom);
        else                queue_frame(4'($urandom), $urandom_range(256, 300), 1'b1, $urandom);
    endtask

    // Close the stream with one faulty header, then trailing bytes to drop.
    task automatic queue_broken_header();
        logic [wfu_pkg::CodeW-1:0] which;
        which = wfu_pkg::CodeW'($urandom_range(0, 3));
        case (which)
            wfu_pkg::ERR_NOT_FINAL: stream_bytes.push_back({1'b0, 7'($urandom)});
            wfu_pkg::ERR_RSV_SET:   stream_bytes.push_back({1'b1, 3'($urandom_range(1, 7)),
                                                            4'($urandom)});
            wfu_pkg::ERR_NO_MASK: begin
                stream_bytes.push_back(wfu_pkg::FIN_BIT | {4'd0, 4'($urandom)});
                stream_bytes.push_back({1'b0, 7'($urandom)});
            end
            default: begin
                stream_bytes.push_back(wfu_pkg::FIN_BIT | {4'd0, 4'($urandom)});
                stream_bytes.push_back({1'b1, wfu_pkg::LEN_EXT64});
            end
        endcase
        repeat ($urandom_range(3, 8)) stream_bytes.push_back(wfu_pkg::ByteW'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer the next byte at the falling edge, retire it when taken.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && !byte_busy) begin
            if (send_gap > 0 || stream_bytes.size() == 0) begin
                i_in_valid <= 1'b0;
                if (send_gap > 0) send_gap--;
            end else begin
                i_in_valid <= 1'b1;
                i_in_byte  <= stream_bytes[0];
                byte_busy   = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            unmask_byte(i_in_byte);
            void'(stream_bytes.pop_front());
            byte_busy = 1'b0;
            send_gap  = idle_len();
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, calm stretches, and one long hold-off that
    // backs the pipeline up while the driver keeps offering requests.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            cycle_count++;
            if (cycle_count % 256 == 0) calm = ($urandom_range(0, 3) == 0);
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                stall_left = idle_len();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_frame_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind=%0d byte=%02h",
                                          o_out_kind, o_out_byte));
            end else begin
                want = expected_results.pop_front();
                if (o_out_kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", o_out_kind, want.kind));
                if (o_out_byte !== want.data)
                    report_mismatch($sformatf("byte %02h, want %02h", o_out_byte, want.data));
                if (o_last_of_frame !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b",
                                              o_last_of_frame, want.last));
                if (o_error_code !== want.code)
                    report_mismatch($sformatf("error code %0d, want %0d",
                                              o_error_code, want.code));
            end
        end
    end

    // Count cycles in which neither channel completes a handshake.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence: build the stream, release reset, drain, decide.
    // ------------------------------------------------------------------------
    initial begin
        // Directed: one byte under a zero key, an empty frame under an all-ones
        // key with every opcode bit set, an extended length of zero, and a
        // short extended length whose payload wraps the key.
        queue_frame(4'h1, 1, 1'b0, 32'h0000_0000);
        queue_frame(4'hF, 0, 1'b0, 32'hFFFF_FFFF);
        queue_frame(4'h0, 0, 1'b1, 32'h1234_5678);
        queue_frame(4'h2, 5, 1'b1, 32'hA55A_0FF0);

        // Random well-formed frames, then the one fault that halts the block.
        while (stream_bytes.size() < ITEM_TARGET) queue_random_frame();
        queue_broken_header();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stream_bytes.size() != 0 || byte_busy) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
